// ===== hw/rtl/mofas_pkg.sv =====
package mofas_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int VOLT_W          = 21;
    localparam int WEIGHT_W        = 5;
    localparam int GAIN_W          = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 3;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 24;
    localparam int DEF_SAMPLES     = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_POLARITY = 1'd1;

    // Gain codes of the converter.
    localparam logic [GAIN_W-1:0] GAIN_2_3X = 3'd0;
    localparam logic [GAIN_W-1:0] GAIN_1X   = 3'd1;
    localparam logic [GAIN_W-1:0] GAIN_2X   = 3'd2;
    localparam logic [GAIN_W-1:0] GAIN_4X   = 3'd3;
    localparam logic [GAIN_W-1:0] GAIN_8X   = 3'd4;
    localparam logic [GAIN_W-1:0] GAIN_16X  = 3'd5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Weight in units of 7.8125 uV per bit; unsupported codes give zero.
    function automatic logic [WEIGHT_W-1:0] gain_weight(input logic [GAIN_W-1:0] code);
        logic [WEIGHT_W-1:0] w;
        case (code)
            GAIN_2_3X: w = 5'd24;
            GAIN_1X:   w = 5'd16;
            GAIN_2X:   w = 5'd8;
            GAIN_4X:   w = 5'd4;
            GAIN_8X:   w = 5'd2;
            GAIN_16X:  w = 5'd1;
            default:   w = 5'd0;
        endcase
        return w;
    endfunction

    // Two's complement negation, with the most negative value saturating.
    function automatic t_sample negate_sat(input t_sample s);
        t_sample r;
        if (s == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            r = -s;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/median_of_five_adc_scaler.sv =====
// The beat that completes a set loads the set register; the median and scaling stage
// then loads the output register when it is free. Throughput: one input beat per cycle,
// unless the set register is full and the output stalled; one result beat per
// SAMPLES_PER_RESULT input beats. The median is found by parallel rank counting, so no
// stage iterates. Reset (synchronous, active low) clears the fill count, the valid flags
// and the configuration registers; held readings are not cleared.
module median_of_five_adc_scaler #(
    parameter int SAMPLES_PER_RESULT = mofas_pkg::DEF_SAMPLES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mofas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mofas_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [mofas_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [15:0] raw_sample
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [mofas_pkg::OUT_TDATA_W-1:0]    o_m_tdata    // [20:0] voltage, [23:21] zero
);
    import mofas_pkg::*;

    localparam int N          = SAMPLES_PER_RESULT;
    localparam int HOLD_DEPTH = N - 1;
    localparam int CNT_W      = $clog2(N);
    localparam int HIDX_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int RANK_W     = $clog2(N);
    localparam int MED_RANK   = N / 2;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 1;

    logic [GAIN_W-1:0]  r_gain;
    logic               r_rev;
    t_sample            r_held [0:HOLD_DEPTH-1];
    logic [CNT_W-1:0]   r_fill;
    t_sample            r_set [0:N-1];
    logic [GAIN_W-1:0]  r_set_gain;
    logic               r_set_valid;
    logic               r_out_valid;
    logic [VOLT_W-1:0]  r_voltage;

    t_sample               s_sample;
    logic                  s_acc;
    logic                  s_last;
    logic                  b_load;
    logic [RANK_W-1:0]     rank [0:N-1];
    t_sample               med;
    logic signed [PROD_W-1:0] prod;
    logic [VOLT_W-1:0]     n_voltage;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_2_3X;
            r_rev  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN_CODE:    r_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_REV_POLARITY: r_rev  <= i_cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign b_load     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_set_valid || b_load;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_last     = (r_fill == CNT_W'(HOLD_DEPTH));
    assign s_sample   = r_rev ? negate_sat(t_sample'(i_s_tdata[SAMPLE_W-1:0]))
                              : t_sample'(i_s_tdata[SAMPLE_W-1:0]);

    // Holding store and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (s_acc) begin
            if (s_last) begin
                r_fill <= '0;
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && !s_last) begin
            r_held[r_fill[HIDX_W-1:0]] <= s_sample;
        end
    end

    // Set register: a snapshot of the whole set, taken on the completing beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_valid <= 1'b0;
        end else if (s_acc && s_last) begin
            r_set_valid <= 1'b1;
        end else if (b_load) begin
            r_set_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && s_last) begin
            for (int k = 0; k < HOLD_DEPTH; k++) begin
                r_set[k] <= r_held[k];
            end
            r_set[N-1] <= s_sample;
            r_set_gain <= r_gain;
        end
    end

    // Each element counts the elements below it; equal values are ordered by position,
    // so the ranks are distinct and exactly one element has the middle rank.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            rank[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (j != i) begin
                    if ((r_set[j] < r_set[i]) || ((r_set[j] == r_set[i]) && (j < i))) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        med = '0;
        for (int i = 0; i < N; i++) begin
            if (rank[i] == RANK_W'(MED_RANK)) begin
                med = med | r_set[i];
            end
        end
    end

    assign prod      = med * $signed({1'b0, gain_weight(r_set_gain)});
    assign n_voltage = prod[VOLT_W-1:0];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_load) begin
            r_out_valid <= r_set_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load && r_set_valid) begin
            r_voltage <= n_voltage;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-VOLT_W){1'b0}}, r_voltage};

`ifndef ASSERT_OFF
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(HOLD_DEPTH))
        else $error("fill count beyond the set size");

    a_set_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_last) |=> r_set_valid)
        else $error("completing beat did not load the set register");

    a_set_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_set_valid && b_load) |=> r_out_valid)
        else $error("set register drained without producing a result");

    a_no_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_acc |=> $stable(r_fill))
        else $error("fill count moved without an accepted beat");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_set_valid && (r_fill == '0)))
        else $error("reset left control state set");
`endif

endmodule

// ===== tb/tb_median_of_five_adc_scaler.sv =====
`timescale 1ns / 1ps

module tb_median_of_five_adc_scaler;
    import mofas_pkg::*;

    localparam int SET_SIZE      = 5;
    localparam int HOLD_DEPTH    = SET_SIZE - 1;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int MAX_REPORTS   = 10;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [15:0] raw_sample
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [20:0] voltage, [23:21] zero

    // Shadow copy of the block's registers and held readings.
    logic [GAIN_W-1:0]      gain_code;
    logic                   rev_polarity;
    t_sample                held_readings [HOLD_DEPTH];
    int                     held_count;

    logic signed [VOLT_W-1:0] expected_voltages [$];

    bit      gaps_on   = 1'b0;
    bit      stalls_on = 1'b0;
    t_sample cluster_base;
    int      readings_sent;
    int      medians_checked;
    int      register_writes;
    int      fail_count;

    median_of_five_adc_scaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL median_of_five_adc_scaler");
        $finish;
    end

    // Result side: random stalls, mostly short, now and then a long one.
    initial begin : result_ready_driver
        int stall_len;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stalls_on && $urandom_range(0, 99) < 25) begin
                stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
                i_m_tready = 1'b0;
                repeat (stall_len - 1) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        logic signed [VOLT_W-1:0] want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (expected_voltages.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%06h with none expected", o_m_tdata));
            end else begin
                want = expected_voltages.pop_front();
                medians_checked++;
                if (o_m_tdata !== {{(OUT_TDATA_W-VOLT_W){1'b0}}, want}) begin
                    report_mismatch($sformatf("voltage expected %0d (0x%06h), got 0x%06h",
                                              want, {{(OUT_TDATA_W-VOLT_W){1'b0}}, want},
                                              o_m_tdata));
                end
            end
        end
    end

    // Applies polarity as the reading arrives; the fifth reading of a set
    // yields the median scaled by the gain in force at that moment.
    task automatic take_reading(input t_sample raw);
        t_sample v;
        t_sample set_vals [SET_SIZE];
        t_sample tmp;
        int      weight;
        int      scaled;
        v = raw;
        if (rev_polarity) begin
            v = (raw == 16'sh8000) ? 16'sh7fff : -raw;
        end
        if (held_count < HOLD_DEPTH) begin
            held_readings[held_count] = v;
            held_count++;
        end else begin
            for (int i = 0; i < HOLD_DEPTH; i++) set_vals[i] = held_readings[i];
            set_vals[HOLD_DEPTH] = v;
            for (int i = 0; i < SET_SIZE - 1; i++) begin
                for (int j = 0; j < SET_SIZE - 1 - i; j++) begin
                    if (set_vals[j] > set_vals[j+1]) begin
                        tmp = set_vals[j];
                        set_vals[j] = set_vals[j+1];
                        set_vals[j+1] = tmp;
                    end
                end
            end
            case (gain_code)
                GAIN_2_3X: weight = 24;
                GAIN_1X:   weight = 16;
                GAIN_2X:   weight = 8;
                GAIN_4X:   weight = 4;
                GAIN_8X:   weight = 2;
                GAIN_16X:  weight = 1;
                default:   weight = 0;
            endcase
            scaled = int'(set_vals[SET_SIZE/2]) * weight;
            expected_voltages.push_back(scaled[VOLT_W-1:0]);
            held_count = 0;
        end
    endtask

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // is taken, with valid still high so the next beat can follow at once.
    task automatic send_reading(input t_sample raw);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = raw;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        take_reading(raw);
        readings_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_five(input t_sample a, input t_sample b, input t_sample c,
                             input t_sample d, input t_sample e);
        send_reading(a);
        send_reading(b);
        send_reading(c);
        send_reading(d);
        send_reading(e);
    endtask

    // Holds the input side until every expected median has come out and the
    // pipeline has had time to empty.
    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (expected_voltages.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_GAIN_CODE:    gain_code    = value;
            CFG_REV_POLARITY: rev_polarity = value[0];
            default: ;
        endcase
        register_writes++;
    endtask

    function automatic t_sample random_reading();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh8001;
                3:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        // Readings bunched around one value give ties in the sort.
        if (pick < 3) return cluster_base + t_sample'($urandom_range(0, 2)) - 16'sd1;
        return t_sample'($urandom);
    endfunction

    // Reset values: gain 2/3x and no reversal, checked at both ends of the range.
    task automatic test_reset_defaults();
        send_five(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000);
        send_five(16'sh8000, 16'sd5, 16'sh8000, 16'sd7, 16'sh8000);
    endtask

    task automatic test_polarity_saturation();
        write_register(CFG_GAIN_CODE, GAIN_16X);
        write_register(CFG_REV_POLARITY, 3'd1);
        send_five(16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh8000);
        send_five(16'sh7fff, 16'shffff, 16'sh0001, 16'sh8001, 16'sh8000);
    endtask

    // Register changes with part of a set held: polarity follows each reading,
    // the gain is the one in force when the set completes.
    task automatic test_mid_set_changes();
        send_reading(16'sh1234);
        send_reading(16'sh8000);
        write_register(CFG_REV_POLARITY, 3'd0);
        write_register(CFG_GAIN_CODE, 3'd6);
        send_reading(16'sh0100);
        send_reading(16'sh7ffe);
        send_reading(16'shc000);
        write_register(CFG_GAIN_CODE, 3'd7);
        send_five(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
    endtask

    task automatic test_random_stream();
        int phase;
        int phase_len;
        int start_count;
        phase = 0;
        start_count = readings_sent;
        while (readings_sent - start_count < RANDOM_ITEMS) begin
            // The first phases walk through every supported gain in turn.
            if (phase < 6 || $urandom_range(0, 1) == 1) begin
                write_register(CFG_GAIN_CODE, (phase < 6) ? 3'(phase) :
                               ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5))
                                                          : 3'($urandom_range(6, 7)));
            end
            if (phase < 2 || $urandom_range(0, 1) == 1) begin
                write_register(CFG_REV_POLARITY, 3'(phase == 1 ? 1 : $urandom_range(0, 1)));
            end
            gaps_on   = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
            stalls_on = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
            cluster_base = t_sample'($urandom);
            phase_len = $urandom_range(20, 180);
            repeat (phase_len) send_reading(random_reading());
            phase++;
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_GAIN_CODE;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        gain_code    = GAIN_2_3X;
        rev_polarity = 1'b0;
        held_count   = 0;
        for (int i = 0; i < HOLD_DEPTH; i++) held_readings[i] = '0;
        cluster_base    = '0;
        readings_sent   = 0;
        medians_checked = 0;
        register_writes = 0;
        fail_count      = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_reset_defaults();
        test_polarity_saturation();
        test_mid_set_changes();
        test_random_stream();
        wait_idle();

        $display("Run covered %0d readings and %0d checked medians over %0d register writes,",
                 readings_sent, medians_checked, register_writes);
        $display("with every gain code, both polarities and sets split across register changes.");
        if (fail_count == 0 && expected_voltages.size() == 0) begin
            $display("PASS median_of_five_adc_scaler");
        end else begin
            $display("%0d mismatches, %0d medians never seen", fail_count,
                     expected_voltages.size());
            $display("FAIL median_of_five_adc_scaler");
        end
        $finish;
    end

endmodule
